### src/cdq_pkg.sv
// Package: shared types and codes for the circular deque.
`default_nettype none
package cdq_pkg;

    localparam int DATA_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PEEK_FRONT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PEEK_REAR  = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

endpackage
`default_nettype wire

### src/cdq_if.sv
// Interfaces: operation request channel and result channel.
`default_nettype none
interface cdq_req_if;
    logic                                valid;
    logic                                ready;
    logic        [cdq_pkg::MODE_W-1:0]   mode;
    logic signed [cdq_pkg::DATA_W-1:0]   value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface cdq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic        [cdq_pkg::STATUS_W-1:0] status;
    logic signed [cdq_pkg::DATA_W-1:0]   data;
    logic        [cdq_pkg::OCC_W-1:0]    occupancy;

    modport source (output valid, output status, output data, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input data, input occupancy,
                    output ready);
endinterface
`default_nettype wire

### src/cdq_mem.sv
// Element store: single-port synchronous RAM with registered read data.
`default_nettype none
module cdq_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire                             i_clk,
    input  wire  cdq_pkg::t_mem_ctl         i_ctl,
    input  wire         [AW-1:0]            i_addr,
    input  wire  signed [cdq_pkg::DATA_W-1:0] i_wdata,
    output logic signed [cdq_pkg::DATA_W-1:0] o_rdata
);

    logic signed [cdq_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic signed [cdq_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### src/cdq_ctrl.sv
// Control: head/tail/count registers, operation decode and result handshake.
`default_nettype none
module cdq_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_req_valid,
    output logic                             o_req_ready,
    input  wire  [cdq_pkg::MODE_W-1:0]       i_mode,
    output logic                             o_rsp_valid,
    input  wire                              i_rsp_ready,
    output logic [cdq_pkg::STATUS_W-1:0]     o_status,
    output logic [cdq_pkg::OCC_W-1:0]        o_occupancy,
    output logic                             o_has_data,
    output cdq_pkg::t_mem_ctl                o_mem_ctl,
    output logic [AW-1:0]                    o_mem_addr
);

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cdq_pkg::t_state r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [cdq_pkg::STATUS_W-1:0] r_status, n_status;
    logic r_has_data, n_has_data;

    logic accept;
    logic full, empty;
    logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;

    assign accept   = i_req_valid && o_req_ready;
    assign full     = (r_count == FULL_CNT);
    assign empty    = (r_count == '0);
    assign head_inc = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);
    assign head_dec = (r_head == '0) ? LAST_IDX : r_head - AW'(1);
    assign tail_inc = (r_tail == LAST_IDX) ? '0 : r_tail + AW'(1);
    assign tail_dec = (r_tail == '0) ? LAST_IDX : r_tail - AW'(1);

    // operation decode
    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_status   = r_status;
        n_has_data = r_has_data;
        o_mem_ctl  = '0;
        o_mem_addr = r_head;
        if (accept) begin
            n_status   = cdq_pkg::STATUS_DONE;
            n_has_data = 1'b0;
            case (i_mode)
                cdq_pkg::MODE_PUSH_FRONT: begin
                    if (full) begin
                        n_status = cdq_pkg::STATUS_FULL;
                    end else begin
                        o_mem_ctl.we = 1'b1;
                        o_mem_addr   = head_dec;
                        n_head       = head_dec;
                        n_count      = r_count + CW'(1);
                    end
                end
                cdq_pkg::MODE_PUSH_REAR: begin
                    if (full) begin
                        n_status = cdq_pkg::STATUS_FULL;
                    end else begin
                        o_mem_ctl.we = 1'b1;
                        o_mem_addr   = r_tail;
                        n_tail       = tail_inc;
                        n_count      = r_count + CW'(1);
                    end
                end
                cdq_pkg::MODE_POP_FRONT: begin
                    if (empty) begin
                        n_status = cdq_pkg::STATUS_EMPTY;
                    end else begin
                        o_mem_ctl.re = 1'b1;
                        o_mem_addr   = r_head;
                        n_has_data   = 1'b1;
                        n_head       = head_inc;
                        n_count      = r_count - CW'(1);
                    end
                end
                cdq_pkg::MODE_POP_REAR: begin
                    if (empty) begin
                        n_status = cdq_pkg::STATUS_EMPTY;
                    end else begin
                        o_mem_ctl.re = 1'b1;
                        o_mem_addr   = tail_dec;
                        n_has_data   = 1'b1;
                        n_tail       = tail_dec;
                        n_count      = r_count - CW'(1);
                    end
                end
                cdq_pkg::MODE_PEEK_FRONT: begin
                    if (empty) begin
                        n_status = cdq_pkg::STATUS_EMPTY;
                    end else begin
                        o_mem_ctl.re = 1'b1;
                        o_mem_addr   = r_head;
                        n_has_data   = 1'b1;
                    end
                end
                cdq_pkg::MODE_PEEK_REAR: begin
                    if (empty) begin
                        n_status = cdq_pkg::STATUS_EMPTY;
                    end else begin
                        o_mem_ctl.re = 1'b1;
                        o_mem_addr   = tail_dec;
                        n_has_data   = 1'b1;
                    end
                end
                default: begin
                    n_status = cdq_pkg::STATUS_DONE;
                end
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cdq_pkg::ST_IDLE: begin
                if (accept) n_state = cdq_pkg::ST_RESP;
            end
            cdq_pkg::ST_RESP: begin
                if (i_rsp_ready && !accept) n_state = cdq_pkg::ST_IDLE;
            end
            default: begin
                n_state = cdq_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_rsp_valid = 1'b0;
        o_req_ready = 1'b1;
        case (r_state)
            cdq_pkg::ST_IDLE: begin
                o_rsp_valid = 1'b0;
                o_req_ready = 1'b1;
            end
            cdq_pkg::ST_RESP: begin
                o_rsp_valid = 1'b1;
                o_req_ready = i_rsp_ready;
            end
            default: begin
                o_rsp_valid = 1'b0;
                o_req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= cdq_pkg::ST_IDLE;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_status   <= cdq_pkg::STATUS_DONE;
            r_has_data <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_count    <= n_count;
            r_status   <= n_status;
            r_has_data <= n_has_data;
        end
    end

    assign o_status    = r_status;
    assign o_occupancy = cdq_pkg::OCC_W'(r_count);
    assign o_has_data  = r_has_data;

endmodule
`default_nettype wire

### src/circular_deque.sv
// Top level: double-ended queue over a circular RAM of signed words.
//
//  channel   | dir | payload                     | beat when
//  ----------+-----+-----------------------------+-------------------
//  i_req     | in  | mode, value                 | valid && ready
//  o_rsp     | out | status, data, occupancy     | valid && ready
//
// An operation is decoded and issued to the RAM in the cycle it is taken;
// its result is shown from the next cycle on, with read data from the RAM
// output register. One operation per cycle while o_rsp is taken at once.
// i_req.ready follows o_rsp.ready while a result is pending, so a stalled
// result holds and no new beat enters. Reset clears indices and count;
// the RAM needs no clearing.
`default_nettype none
module circular_deque #(
    parameter int DEPTH = 16
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    cdq_req_if.sink   i_req,
    cdq_rsp_if.source o_rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cdq_pkg::t_mem_ctl mem_ctl;
    logic [AW-1:0] mem_addr;
    logic signed [cdq_pkg::DATA_W-1:0] mem_rdata;
    logic has_data;

    cdq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_mode      (i_req.mode),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_status    (o_rsp.status),
        .o_occupancy (o_rsp.occupancy),
        .o_has_data  (has_data),
        .o_mem_ctl   (mem_ctl),
        .o_mem_addr  (mem_addr)
    );

    cdq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_wdata (i_req.value),
        .o_rdata (mem_rdata)
    );

    assign o_rsp.data = has_data ? mem_rdata : '0;

endmodule
`default_nettype wire

### src/cdq_chk.sv
// Checker: port-level assertions for the circular deque, bound to the top.
`default_nettype none
module cdq_chk #(
    parameter int DEPTH = 16
) (
    input wire                               i_clk,
    input wire                               i_rst_n,
    input wire                               i_rsp_valid,
    input wire                               i_rsp_ready,
    input wire [cdq_pkg::STATUS_W-1:0]       i_status,
    input wire [cdq_pkg::DATA_W-1:0]         i_data,
    input wire [cdq_pkg::OCC_W-1:0]          i_occupancy
);

    localparam logic [cdq_pkg::OCC_W-1:0] FULL_OCC = cdq_pkg::OCC_W'(DEPTH);

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_status == cdq_pkg::STATUS_FULL)
            |-> (i_occupancy == FULL_OCC && i_data == '0))
        else $error("full refusal with wrong occupancy or data");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_status == cdq_pkg::STATUS_EMPTY)
            |-> (i_occupancy == '0 && i_data == '0))
        else $error("empty refusal with wrong occupancy or data");

    a_no_rsp_after_rst: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> !i_rsp_valid)
        else $error("result beat right after reset");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready)
            |=> (i_rsp_valid && $stable(i_data) && $stable(i_occupancy)))
        else $error("stalled result changed");

endmodule

bind circular_deque cdq_chk #(.DEPTH(DEPTH)) u_cdq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_data      (o_rsp.data),
    .i_occupancy (o_rsp.occupancy)
);
`default_nettype wire

### tb/sv/tb_top.sv
// Self-checking testbench for circular_deque: directed table, then random beats.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cdq_pkg::*;

    localparam int DEPTH     = 16;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int N_RANDOM  = 1200;
    localparam int MAX_CYCLES = 300000;
    localparam int TAIL_CYCLES = 16;
    localparam int MAX_PRINTS = 40;

    localparam logic [MODE_W-1:0] MODE_NOP_6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_NOP_7 = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] data;
        logic [OCC_W-1:0]         occupancy;
    } t_deque_rsp;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] value;
        int                       reps;
        logic                     literal;
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] data;
        logic [OCC_W-1:0]         occupancy;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    cdq_req_if req_if ();
    cdq_rsp_if rsp_if ();

    circular_deque #(
        .DEPTH (DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // shadow deque
    logic signed [DATA_W-1:0] shadow_mem [DEPTH];
    logic [IDX_W-1:0]         front_idx;
    logic [IDX_W-1:0]         rear_idx;
    logic [OCC_W-1:0]         fill;

    t_deque_rsp predicted_rsp_q [$];
    int         mismatch_count;
    int         cycle_cnt;
    bit         send_no_idle;
    int         push_pct;

    t_dir_row dir_rows [24];

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - IDX_W'(1);
    endfunction

    function automatic t_deque_rsp deque_apply(input logic [MODE_W-1:0] op,
                                               input logic signed [DATA_W-1:0] val);
        t_deque_rsp r;
        r.status = STATUS_DONE;
        r.data   = '0;
        case (op)
            MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
                if (fill == OCC_W'(DEPTH)) begin
                    r.status = STATUS_FULL;
                end else if (op == MODE_PUSH_FRONT) begin
                    front_idx = idx_dec(front_idx);
                    shadow_mem[front_idx] = val;
                    fill = fill + OCC_W'(1);
                end else begin
                    shadow_mem[rear_idx] = val;
                    rear_idx = idx_inc(rear_idx);
                    fill = fill + OCC_W'(1);
                end
            end
            MODE_POP_FRONT, MODE_POP_REAR, MODE_PEEK_FRONT, MODE_PEEK_REAR: begin
                if (fill == '0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    case (op)
                        MODE_POP_FRONT: begin
                            r.data = shadow_mem[front_idx];
                            front_idx = idx_inc(front_idx);
                            fill = fill - OCC_W'(1);
                        end
                        MODE_POP_REAR: begin
                            rear_idx = idx_dec(rear_idx);
                            r.data = shadow_mem[rear_idx];
                            fill = fill - OCC_W'(1);
                        end
                        MODE_PEEK_FRONT: r.data = shadow_mem[front_idx];
                        default:         r.data = shadow_mem[idx_dec(rear_idx)];
                    endcase
                end
            end
            default: ;
        endcase
        r.occupancy = fill;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTS)
            $display("[cycle %0d] %s", cycle_cnt, msg);
        mismatch_count++;
    endtask

    task automatic drive_op(input logic [MODE_W-1:0] op, input logic signed [DATA_W-1:0] val);
        int gap;
        gap = send_no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.mode  <= op;
        req_if.value <= val;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic drain_pause();
        req_if.valid <= 1'b0;
        while (predicted_rsp_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic pick_random_op(output logic [MODE_W-1:0] op,
                                  output logic signed [DATA_W-1:0] val);
        int r;
        r = $urandom_range(0, 99);
        if (r < 1) begin
            op = $urandom_range(0, 1) ? MODE_NOP_6 : MODE_NOP_7;
        end else begin
            r = $urandom_range(0, 99);
            if (r < push_pct)
                op = $urandom_range(0, 1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
            else if (r < push_pct + (100 - push_pct) * 3 / 4)
                op = $urandom_range(0, 1) ? MODE_POP_REAR : MODE_POP_FRONT;
            else
                op = $urandom_range(0, 1) ? MODE_PEEK_REAR : MODE_PEEK_FRONT;
        end
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0:       val = VAL_MAX;
                    1:       val = VAL_MIN;
                    2:       val = '0;
                    default: val = -1;
                endcase
            end
            default: val = $urandom;
        endcase
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < MAX_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Mismatches found");
        $finish;
    end

    // result checker: beat at valid && ready
    always @(posedge i_clk) begin
        t_deque_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (predicted_rsp_q.size() == 0) begin
                report_mismatch($sformatf("result beat with none pending: status %0d data %0h",
                                          rsp_if.status, rsp_if.data));
            end else begin
                want = predicted_rsp_q.pop_front();
                if (rsp_if.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              rsp_if.status, want.status));
                if (rsp_if.data !== want.data)
                    report_mismatch($sformatf("data got %0h want %0h",
                                              rsp_if.data, want.data));
                if (rsp_if.occupancy !== want.occupancy)
                    report_mismatch($sformatf("occupancy got %0d want %0d",
                                              rsp_if.occupancy, want.occupancy));
            end
        end
    end

    // result sink with random stalls
    initial begin : rsp_sink
        int stall;
        int n_seen;
        bit sink_no_idle;
        rsp_if.ready <= 1'b0;
        n_seen       = 0;
        sink_no_idle = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (n_seen % 50 == 0)
                sink_no_idle = ($urandom_range(0, 3) == 0);
            stall = sink_no_idle ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_if.valid && rsp_if.ready));
            n_seen++;
        end
    end

    initial begin : stimulus
        logic [MODE_W-1:0]        op;
        logic signed [DATA_W-1:0] val;
        t_deque_rsp               p;
        t_deque_rsp               lit;

        mismatch_count = 0;
        front_idx      = '0;
        rear_idx       = '0;
        fill           = '0;
        send_no_idle   = 1'b0;
        push_pct       = 50;
        for (int i = 0; i < DEPTH; i++) shadow_mem[i] = '0;

        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.mode  <= MODE_PUSH_FRONT;
        req_if.value <= '0;

        dir_rows = '{
            '{MODE_POP_FRONT,  0,       1,  1'b1, STATUS_EMPTY, 0,       0},
            '{MODE_POP_REAR,   -1,      1,  1'b1, STATUS_EMPTY, 0,       0},
            '{MODE_PEEK_FRONT, VAL_MAX, 1,  1'b1, STATUS_EMPTY, 0,       0},
            '{MODE_PEEK_REAR,  VAL_MIN, 1,  1'b1, STATUS_EMPTY, 0,       0},
            '{MODE_NOP_6,      -1,      1,  1'b1, STATUS_DONE,  0,       0},
            '{MODE_NOP_7,      0,       1,  1'b1, STATUS_DONE,  0,       0},
            '{MODE_PUSH_FRONT, VAL_MAX, 1,  1'b1, STATUS_DONE,  0,       1},
            '{MODE_PUSH_REAR,  VAL_MIN, 1,  1'b1, STATUS_DONE,  0,       2},
            '{MODE_PEEK_FRONT, 0,       1,  1'b1, STATUS_DONE,  VAL_MAX, 2},
            '{MODE_PEEK_REAR,  0,       1,  1'b1, STATUS_DONE,  VAL_MIN, 2},
            '{MODE_NOP_7,      -1,      1,  1'b1, STATUS_DONE,  0,       2},
            '{MODE_POP_REAR,   0,       1,  1'b1, STATUS_DONE,  VAL_MIN, 1},
            '{MODE_POP_FRONT,  0,       1,  1'b1, STATUS_DONE,  VAL_MAX, 0},
            '{MODE_PUSH_FRONT, 1,       9,  1'b0, STATUS_DONE,  0,       0},
            '{MODE_PUSH_REAR,  100,     7,  1'b0, STATUS_DONE,  0,       0},
            '{MODE_PUSH_REAR,  5,       1,  1'b1, STATUS_FULL,  0,       16},
            '{MODE_PUSH_FRONT, -1,      1,  1'b1, STATUS_FULL,  0,       16},
            '{MODE_PEEK_FRONT, 0,       1,  1'b0, STATUS_DONE,  0,       0},
            '{MODE_PEEK_REAR,  0,       1,  1'b0, STATUS_DONE,  0,       0},
            '{MODE_POP_REAR,   0,       10, 1'b0, STATUS_DONE,  0,       0},
            '{MODE_POP_FRONT,  0,       6,  1'b0, STATUS_DONE,  0,       0},
            '{MODE_POP_FRONT,  0,       1,  1'b1, STATUS_EMPTY, 0,       0},
            '{MODE_PUSH_REAR,  0,       1,  1'b1, STATUS_DONE,  0,       1},
            '{MODE_POP_FRONT,  0,       1,  1'b1, STATUS_DONE,  0,       0}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            for (int k = 0; k < dir_rows[i].reps; k++) begin
                val = dir_rows[i].value + k;
                drive_op(dir_rows[i].mode, val);
                p = deque_apply(dir_rows[i].mode, val);
                lit.status    = dir_rows[i].status;
                lit.data      = dir_rows[i].data;
                lit.occupancy = dir_rows[i].occupancy;
                predicted_rsp_q.push_back(dir_rows[i].literal ? lit : p);
            end
        end
        drain_pause();

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 48 == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_pct = 15;
                    1:       push_pct = 50;
                    default: push_pct = 85;
                endcase
                send_no_idle = ($urandom_range(0, 3) == 0);
            end
            if (n == N_RANDOM / 2)
                drain_pause();
            pick_random_op(op, val);
            drive_op(op, val);
            predicted_rsp_q.push_back(deque_apply(op, val));
        end

        req_if.valid <= 1'b0;
        while (predicted_rsp_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && predicted_rsp_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### sim.f
src/cdq_pkg.sv
src/cdq_if.sv
src/cdq_mem.sv
src/cdq_ctrl.sv
src/circular_deque.sv
src/cdq_chk.sv
tb/sv/tb_top.sv
